// File: hdl/cwrap_pkg.sv
// types, codes and field layout shared by the console word-wrap writer and its checker
package cwrap_pkg;

  // defaults for the top-level parameters
  localparam int MAX_LINE_WIDTH_DEF = 63;
  localparam int TEXT_BYTES_DEF     = 16384;

  // field widths
  localparam int CHAR_W      = 8;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 14;
  localparam int CNT_W       = 15;
  localparam int ACT_W       = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 15;

  // result tdata layout
  localparam int OUT_COL_LSB  = ROW_W;
  localparam int OUT_CODE_LSB = OUT_COL_LSB + COL_W;
  localparam int OUT_ADV_BIT  = OUT_CODE_LSB + CHAR_W;

  localparam int ROW_LIMIT     = 16384;
  localparam int DEFAULT_WIDTH = 38;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_HIGH    = 8'h80;
  localparam logic [CHAR_W-1:0] PFX_ALERT  = 8'h01;
  localparam logic [CHAR_W-1:0] PFX_COLOR  = 8'h02;

  typedef enum logic [ACT_W-1:0] {
    ACT_CTRL  = 2'd0,
    ACT_PLACE = 2'd1,
    ACT_ALERT = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH = 1'b0,
    REG_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_POP,
    ST_CTRL,
    ST_ALERT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_PUSH,
    PH_LOOP,
    PH_LAST,
    PH_CTRL
  } phase_t;

  typedef struct packed {
    logic              adv;
    action_t           act;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } result_t;

endpackage

// File: hdl/console_word_wrap_writer.sv
// console word-wrap writer: places message bytes into a ring of text rows
module console_word_wrap_writer #(
  parameter int MAX_LINE_WIDTH = cwrap_pkg::MAX_LINE_WIDTH_DEF,
  parameter int TEXT_BYTES     = cwrap_pkg::TEXT_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [cwrap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwrap_pkg::CFG_DATA_W-1:0]  cfg_data,
  // message bytes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cwrap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic                              s_axis_tuser,  // first_of_message
  input  logic                              s_axis_tlast,  // last_of_message
  // placement results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [13:0] row_index, [19:14] column, [27:20] char_code, [28] line_advanced, [31:29] zero
  output logic [cwrap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [cwrap_pkg::ACT_W-1:0]       m_axis_tuser,  // [1:0] action
  output logic                              m_axis_tlast   // last_of_burst
);
  // A message byte is taken only while the writer is idle. Printable bytes
  // (33..127) are held in a small word memory until the word length is known;
  // a byte that ends a word, a new message or the end of a message flushes
  // the held word. Every flushed byte passes the single read port of the word
  // memory and one shared placement unit (wrap test, row advance, column step)
  // in a check / read / place sequence; control bytes share the unit. A byte
  // that is only held passes accept, push, length check and close; a control
  // byte with nothing held passes accept, check, place and close. Every flushed
  // byte adds its check / read / place steps, the first byte of a message a
  // prefix test and the last byte of a message a final length check; a color
  // prefix with nothing held passes accept, check and close, an alert prefix
  // also an alert step. Results pass through a one-deep staging register and
  // an output register, so the consumer may stall at any time; place, alert
  // and close steps wait while the staging register is full and the output is
  // stalled. Configuration writes (register 0 line width, register 1 row
  // count) also move the current row to the last row of the ring and are
  // meant for idle periods only. No clearing pass after reset: the word
  // memory is only read where it was written.

  import cwrap_pkg::*;

  localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int FW = $clog2(MAX_LINE_WIDTH + 1);
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(TEXT_BYTES / DEFAULT_WIDTH);
  localparam logic [COL_W-1:0] MAX_W       = COL_W'(MAX_LINE_WIDTH);
  localparam logic [AW-1:0]    HOLD_LAST   = AW'(MAX_LINE_WIDTH - 1);
  localparam logic [AW:0]      HOLD_DEPTH  = (AW+1)'(MAX_LINE_WIDTH);

  // width 0 acts as 1, beyond the hold depth it saturates
  function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] v);
    logic [COL_W-1:0] r;
    r = v;
    if (v == '0) r = COL_W'(1);
    else if (v > MAX_W) r = MAX_W;
    return r;
  endfunction

  // row count 0 acts as 1, capped at the row limit
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(ROW_LIMIT)) r = CNT_W'(ROW_LIMIT);
    return r;
  endfunction

  localparam logic [ROW_W-1:0] RESET_ROW = ROW_W'(eff_count(RESET_COUNT) - CNT_W'(1));

  // configuration registers
  logic [COL_W-1:0] width_reg;
  logic [CNT_W-1:0] count_reg;

  // console state
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             rp;      // carriage return seen, next byte re-enters the row
  logic             color;

  // held word: circular buffer with head pointer and fill count
  logic [CHAR_W-1:0] hold_mem [MAX_LINE_WIDTH];
  logic [AW-1:0]     head;
  logic [FW-1:0]     fill;
  logic [CHAR_W-1:0] rdata;

  // current item
  logic [CHAR_W-1:0] char_reg;
  logic              last_reg;

  // sequencer
  state_t state, state_next;
  phase_t phase;

  // result staging and output register
  result_t pend;
  logic    pend_valid;
  result_t out_res;
  logic    out_last;
  logic    out_valid;

  // control strobes
  logic emit_go, alert_go, push_go, pop_go, final_go, fetch_go;

  logic [COL_W-1:0] w;
  logic [CNT_W-1:0] n;
  logic [COL_W-1:0] fill_c;
  logic             printable, printable_in, is_prefix;
  logic             out_free, stall;

  assign w            = eff_width(width_reg);
  assign n            = eff_count(count_reg);
  assign fill_c       = COL_W'(fill);
  assign printable    = (char_reg > CH_SPACE) && (char_reg < CH_HIGH);
  assign printable_in = (s_axis_tdata > CH_SPACE) && (s_axis_tdata < CH_HIGH);
  assign is_prefix    = (char_reg == PFX_ALERT) || (char_reg == PFX_COLOR);
  assign out_free     = !out_valid || m_axis_tready;
  assign stall        = pend_valid && !out_free;

  // write slot behind the held word
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  assign tail_sum = (AW+1)'(head) + (AW+1)'(fill);
  assign tail     = (tail_sum >= HOLD_DEPTH) ? AW'(tail_sum - HOLD_DEPTH) : AW'(tail_sum);

  // ---- shared placement unit ----
  logic [CHAR_W-1:0] e_char;
  logic [COL_W-1:0]  e_len;
  logic [COL_W-1:0]  col_base, col0, e_col_next;
  logic [COL_W:0]    fit_sum, col_inc;
  logic [ROW_W-1:0]  row1, e_row;
  logic [CNT_W-1:0]  row_inc;
  logic              e_adv, e_rp;
  result_t           e_res, alert_res, new_res;

  always_comb begin
    // a flushed byte sees the rest of its word, capped at the width
    e_char = (state == ST_CTRL) ? char_reg : rdata;
    if (state == ST_CTRL) e_len = '0;
    else e_len = (fill_c < w) ? fill_c : w;

    col_base = (col >= w) ? '0 : col;
    fit_sum  = {1'b0, col_base} + {1'b0, e_len};
    // a word shorter than the width that does not fit the rest of the row starts a new row
    col0 = ((e_len != w) && (fit_sum > {1'b0, w})) ? '0 : col_base;

    if (rp) begin
      if ((row == '0) || ({1'b0, row} > n)) row1 = ROW_W'(n - CNT_W'(1));
      else row1 = row - ROW_W'(1);
    end else begin
      row1 = row;
    end

    e_adv   = (col0 == '0);
    row_inc = {1'b0, row1} + CNT_W'(1);
    if (e_adv) e_row = (row_inc >= n) ? '0 : ROW_W'(row_inc);
    else e_row = row1;

    col_inc    = {1'b0, col0} + (COL_W+1)'(1);
    e_rp       = 1'b0;
    e_res.row  = e_row;
    e_res.adv  = e_adv;
    e_res.col  = '0;
    e_res.code = '0;
    e_res.act  = ACT_CTRL;
    if (e_char == CH_LF) begin
      e_col_next = '0;
    end else if (e_char == CH_CR) begin
      e_col_next = '0;
      e_rp       = 1'b1;
    end else begin
      e_res.col  = col0;
      e_res.code = e_char | {color, 7'b0};
      e_res.act  = ACT_PLACE;
      e_col_next = (col_inc >= {1'b0, w}) ? '0 : COL_W'(col_inc);
    end

    alert_res.row  = row;
    alert_res.col  = '0;
    alert_res.code = '0;
    alert_res.act  = ACT_ALERT;
    alert_res.adv  = 1'b0;

    new_res = alert_go ? alert_res : e_res;
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        case (phase)
          PH_FIRST: begin
            if (fill != '0) state_next = ST_FETCH;
            else if (is_prefix) state_next = (char_reg == PFX_ALERT) ? ST_ALERT : ST_DONE;
          end
          PH_PUSH: state_next = ST_CHECK;
          PH_LOOP: begin
            if (fill_c >= w) state_next = ST_FETCH;
            else if (!last_reg) state_next = ST_DONE;
          end
          PH_LAST: state_next = (fill != '0) ? ST_FETCH : ST_DONE;
          PH_CTRL: state_next = (fill != '0) ? ST_FETCH : ST_CTRL;
          default: state_next = ST_DONE;
        endcase
      end
      ST_FETCH: state_next = ST_POP;
      ST_POP:   if (!stall) state_next = ST_CHECK;
      ST_CTRL:  if (!stall) state_next = ST_DONE;
      ST_ALERT: if (!stall) state_next = ST_DONE;
      ST_DONE:  if (!stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---- sequencer: strobes ----
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    fetch_go      = (state == ST_FETCH);
    emit_go       = ((state == ST_POP) || (state == ST_CTRL)) && !stall;
    pop_go        = (state == ST_POP) && !stall;
    alert_go      = (state == ST_ALERT) && !stall;
    push_go       = (state == ST_CHECK) && (phase == PH_PUSH);
    final_go      = (state == ST_DONE) && pend_valid && out_free;
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_FIRST;
      width_reg  <= COL_W'(DEFAULT_WIDTH);
      count_reg  <= RESET_COUNT;
      col        <= '0;
      row        <= RESET_ROW;
      rp         <= 1'b0;
      color      <= 1'b0;
      head       <= '0;
      fill       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // a resize also parks the row on the last row of the ring
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) begin
          width_reg <= cfg_data[COL_W-1:0];
          row       <= ROW_W'(n - CNT_W'(1));
        end else begin
          count_reg <= cfg_data[CNT_W-1:0];
          row       <= ROW_W'(eff_count(cfg_data[CNT_W-1:0]) - CNT_W'(1));
        end
      end else if (emit_go) begin
        row <= e_row;
      end

      if (emit_go) begin
        col <= e_col_next;
        rp  <= e_rp;
      end

      // phase of the current item
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) phase <= PH_FIRST;
        else phase <= printable_in ? PH_PUSH : PH_CTRL;
      end else if (state == ST_CHECK) begin
        case (phase)
          PH_FIRST: begin
            if (fill == '0) begin
              if (is_prefix) begin
                color <= 1'b1;
              end else begin
                color <= 1'b0;
                phase <= printable ? PH_PUSH : PH_CTRL;
              end
            end
          end
          PH_PUSH: phase <= PH_LOOP;
          PH_LOOP: if ((fill_c < w) && last_reg) phase <= PH_LAST;
          default: phase <= phase;
        endcase
      end

      // word buffer bookkeeping
      if (push_go) begin
        fill <= fill + FW'(1);
      end else if (pop_go) begin
        fill <= fill - FW'(1);
        head <= (head == HOLD_LAST) ? '0 : head + AW'(1);
      end

      // results: staging register keeps one back so the last can be flagged
      if (emit_go || alert_go) pend_valid <= 1'b1;
      else if (final_go) pend_valid <= 1'b0;

      if (((emit_go || alert_go) && pend_valid) || final_go) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      char_reg <= s_axis_tdata;
      last_reg <= s_axis_tlast;
    end
    if (emit_go || alert_go) begin
      pend <= new_res;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end else if (final_go) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

  // word memory, registered read
  always_ff @(posedge clk) begin
    if (push_go) hold_mem[tail] <= char_reg;
    if (fetch_go) rdata <= hold_mem[head];
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_ADV_BIT - 1)'(0), out_res.adv, out_res.code,
                          out_res.col, out_res.row};
  assign m_axis_tuser  = out_res.act;
  assign m_axis_tlast  = out_last;

endmodule

// File: hdl/cwrap_checker.sv
// port-level checks for the console word-wrap writer, bound to the top level
module cwrap_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [cwrap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [cwrap_pkg::ACT_W-1:0]       m_axis_tuser,
  input logic                              m_axis_tlast
);
  import cwrap_pkg::*;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // while a burst is still open the writer takes no new item
  a_busy_in_burst: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("new item taken before burst ended");

  // alert carries no character, column or advance
  a_alert_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_ALERT) |->
      (m_axis_tdata[OUT_COL_LSB +: COL_W] == '0) &&
      (m_axis_tdata[OUT_CODE_LSB +: CHAR_W] == '0) && !m_axis_tdata[OUT_ADV_BIT])
    else $error("alert result with payload");

  // control byte writes nothing
  a_ctrl_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_CTRL) |->
      (m_axis_tdata[OUT_COL_LSB +: COL_W] == '0) &&
      (m_axis_tdata[OUT_CODE_LSB +: CHAR_W] == '0))
    else $error("control result with character");

endmodule

bind console_word_wrap_writer cwrap_checker u_cwrap_checker (.*);
